/* hw/rtl/indexed_max_priority_task_queue_unit_macros.svh */
// assertion macros for the indexed max priority task queue
// used by the top level only, no other dependencies
`ifndef INDEXED_MAX_PRIORITY_TASK_QUEUE_UNIT_MACROS_SVH
`define INDEXED_MAX_PRIORITY_TASK_QUEUE_UNIT_MACROS_SVH

// condition must hold at every clock edge outside reset
`define IMQT_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("imqt assertion failed");

// antecedent implies consequent in the same cycle
`define IMQT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("imqt assertion failed");

`endif

/* hw/rtl/imqt_pkg.sv */
// shared types, codes and key compare for the task queue
// no dependencies
package imqt_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int ID_W            = 16;
    localparam int USER_W          = 16;
    localparam int PRIO_W          = 32;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_EDIT   = 2'd1,
        OP_REMOVE = 2'd2,
        OP_TAKE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WAVE,
        S_RESOLVE,
        S_DONE
    } state_t;

    // one held task
    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   task_id;
        logic [USER_W-1:0] user;
        logic [PRIO_W-1:0] prio;
    } entry_t;

    // command broadcast from the controller to every cell
    typedef struct packed {
        logic              pop;
        logic              ins;
        logic [ID_W-1:0]   id;
        logic [USER_W-1:0] user;
        logic [PRIO_W-1:0] prio;
    } cmd_t;

    // search token walking down the chain
    typedef struct packed {
        logic              tok;
        logic              found;
        logic [USER_W-1:0] user;
    } wave_t;

    // ordering key: priority first, larger task id wins ties
    function automatic logic key_gt(
        input logic [PRIO_W-1:0] prio_a,
        input logic [ID_W-1:0]   id_a,
        input logic [PRIO_W-1:0] prio_b,
        input logic [ID_W-1:0]   id_b
    );
        return {prio_a, id_a} > {prio_b, id_b};
    endfunction

endpackage

/* hw/rtl/imqt_cell.sv */
// one cell of the sorted task chain
// depends on imqt_pkg
module imqt_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  imqt_pkg::cmd_t  cmd,
    input  imqt_pkg::entry_t left_entry,
    input  logic            left_gt,
    input  imqt_pkg::entry_t right_entry,
    input  imqt_pkg::wave_t wave_in,
    output imqt_pkg::entry_t entry,
    output logic            gt,
    output imqt_pkg::wave_t wave_out
);
    import imqt_pkg::*;

    logic              valid_reg, valid_next;
    logic [ID_W-1:0]   task_reg, task_next;
    logic [USER_W-1:0] user_reg, user_next;
    logic [PRIO_W-1:0] prio_reg, prio_next;
    logic              tok_reg;
    logic              found_reg;
    logic [USER_W-1:0] carry_user_reg;
    logic              match;
    logic              shift_left;

    always_comb
    begin
        match      = valid_reg && (task_reg == cmd.id);
        gt         = !valid_reg || key_gt(cmd.prio, cmd.id, prio_reg, task_reg);
        shift_left = cmd.pop || (tok_reg && (found_reg || match));

        valid_next = valid_reg;
        task_next  = task_reg;
        user_next  = user_reg;
        prio_next  = prio_reg;
        if (shift_left)
        begin
            // close the gap from the right neighbor
            valid_next = right_entry.valid;
            task_next  = right_entry.task_id;
            user_next  = right_entry.user;
            prio_next  = right_entry.prio;
        end
        else if (cmd.ins && gt)
        begin
            if (left_gt)
            begin
                valid_next = left_entry.valid;
                task_next  = left_entry.task_id;
                user_next  = left_entry.user;
                prio_next  = left_entry.prio;
            end
            else
            begin
                valid_next = 1'b1;
                task_next  = cmd.id;
                user_next  = cmd.user;
                prio_next  = cmd.prio;
            end
        end

        entry.valid    = valid_reg;
        entry.task_id  = task_reg;
        entry.user     = user_reg;
        entry.prio     = prio_reg;

        wave_out.tok   = tok_reg;
        wave_out.found = found_reg || match;
        wave_out.user  = match ? user_reg : carry_user_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= wave_in.tok;
            found_reg <= wave_in.found;
        end
    end

    always_ff @(posedge clk)
    begin
        task_reg       <= task_next;
        user_reg       <= user_next;
        prio_reg       <= prio_next;
        carry_user_reg <= wave_in.user;
    end

endmodule

/* hw/rtl/imqt_ctrl.sv */
// command sequencer and result register for the task queue
// depends on imqt_pkg
module imqt_ctrl #(
    parameter int QUEUE_DEPTH = imqt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   op,
    input  logic [imqt_pkg::ID_W-1:0]    task_id,
    input  logic [imqt_pkg::USER_W-1:0]  owner_id,
    input  logic [imqt_pkg::PRIO_W-1:0]  prio,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [imqt_pkg::USER_W-1:0]  user_out,
    output logic [1:0]                   status,
    input  imqt_pkg::entry_t             head,
    input  imqt_pkg::wave_t              wave_end,
    output imqt_pkg::cmd_t               cmd,
    output imqt_pkg::wave_t              wave_start
);
    import imqt_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    state_t            state_reg, state_next;
    op_t               op_reg, op_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [USER_W-1:0] owner_reg, owner_next;
    logic [PRIO_W-1:0] prio_reg, prio_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              found_reg, found_next;
    logic [USER_W-1:0] carry_user_reg, carry_user_next;
    logic [USER_W-1:0] res_user_reg, res_user_next;
    status_t           res_status_reg, res_status_next;
    logic              out_valid_reg, out_valid_next;
    logic [USER_W-1:0] out_user_reg, out_user_next;
    status_t           out_status_reg, out_status_next;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        id_next         = id_reg;
        owner_next      = owner_reg;
        prio_next       = prio_reg;
        count_next      = count_reg;
        found_next      = found_reg;
        carry_user_next = carry_user_reg;
        res_user_next   = res_user_reg;
        res_status_next = res_status_reg;
        out_user_next   = out_user_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        in_ready        = 1'b0;
        cmd.pop         = 1'b0;
        cmd.ins         = 1'b0;
        cmd.id          = id_reg;
        cmd.user        = owner_reg;
        cmd.prio        = prio_reg;
        wave_start      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next    = op_t'(op);
                    id_next    = task_id;
                    owner_next = owner_id;
                    prio_next  = prio;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_user_next   = '0;
                res_status_next = ST_OK;
                if (op_reg == OP_TAKE)
                begin
                    if (count_reg == '0)
                    begin
                        res_status_next = ST_EMPTY;
                    end
                    else
                    begin
                        res_user_next = head.user;
                        cmd.pop       = 1'b1;
                        count_next    = count_reg - CNT_W'(1);
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    wave_start.tok = 1'b1;
                    state_next     = S_WAVE;
                end
            end
            S_WAVE:
            begin
                if (wave_end.tok)
                begin
                    found_next      = wave_end.found;
                    carry_user_next = wave_end.user;
                    state_next      = S_RESOLVE;
                end
            end
            S_RESOLVE:
            begin
                // the search pass has already pulled out a matching task
                case (op_reg)
                    OP_ADD:
                    begin
                        if (found_reg)
                        begin
                            cmd.ins = 1'b1;
                        end
                        else if (count_reg == CNT_W'(QUEUE_DEPTH))
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            cmd.ins    = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    OP_EDIT:
                    begin
                        if (found_reg)
                        begin
                            cmd.ins  = 1'b1;
                            cmd.user = carry_user_reg;
                        end
                        else
                        begin
                            res_status_next = ST_NOT_FOUND;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (found_reg)
                        begin
                            count_next = count_reg - CNT_W'(1);
                        end
                        else
                        begin
                            res_status_next = ST_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        res_status_next = ST_OK;
                    end
                endcase
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_user_next   = res_user_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid = out_valid_reg;
        user_out  = out_user_reg;
        status    = out_status_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        id_reg         <= id_next;
        owner_reg      <= owner_next;
        prio_reg       <= prio_next;
        found_reg      <= found_next;
        carry_user_reg <= carry_user_next;
        res_user_reg   <= res_user_next;
        res_status_reg <= res_status_next;
        out_user_reg   <= out_user_next;
        out_status_reg <= out_status_next;
    end

endmodule

/* hw/rtl/indexed_max_priority_task_queue_unit.sv */
// Indexed max-priority task queue. Tasks live in a chain of QUEUE_DEPTH cells kept sorted by
// priority (larger task id first on equal priority), packed toward cell 0, so the top task
// is always in cell 0. Take-top reads cell 0 and shifts the whole chain by one. Add, edit
// and remove first send a search token down the chain one cell per cycle; the cell holding
// the id drops out and the cells behind it close the gap as the token passes. An add that
// finds room, or an edit of a held id with the old user carried along, then inserts the
// task in one broadcast where every cell compares against its own key. One item is in
// flight at a time; a finished result sits in an output register, so the next input
// transfer can be taken while it waits. A result that finds the output register still
// occupied holds the sequencer until that register is taken.
// Depends on imqt_pkg, imqt_cell, imqt_ctrl and the assertion macro header.
`include "indexed_max_priority_task_queue_unit_macros.svh"

module indexed_max_priority_task_queue_unit #(
    parameter int QUEUE_DEPTH = imqt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   op,
    input  logic [imqt_pkg::ID_W-1:0]    task_id,
    input  logic [imqt_pkg::USER_W-1:0]  owner_id,
    input  logic [imqt_pkg::PRIO_W-1:0]  prio,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [imqt_pkg::USER_W-1:0]  user_out,
    output logic [1:0]                   status
);
    import imqt_pkg::*;

    // per-cell links along the chain
    entry_t                 cell_entry [QUEUE_DEPTH];
    logic                   cell_gt    [QUEUE_DEPTH];
    wave_t                  cell_wave  [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] valid_vec;
    logic [QUEUE_DEPTH-1:0] tok_vec;
    cmd_t                   cmd;
    wave_t                  wave_start;

    // sequencer: accepts commands, drives broadcasts, holds the result register
    imqt_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .task_id    (task_id),
        .owner_id   (owner_id),
        .prio       (prio),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .user_out   (user_out),
        .status     (status),
        .head       (cell_entry[0]),
        .wave_end   (cell_wave[QUEUE_DEPTH-1]),
        .cmd        (cmd),
        .wave_start (wave_start)
    );

    // the cell chain: cell 0 holds the top task, empty cells trail at the far end
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        entry_t left_entry;
        logic   left_gt;
        entry_t right_entry;
        wave_t  wave_in;

        if (i == 0)
        begin : g_first
            // nothing ranks above cell 0, so an insert that beats it lands here
            assign left_entry = '0;
            assign left_gt    = 1'b0;
            assign wave_in    = wave_start;
        end
        else
        begin : g_inner
            assign left_entry = cell_entry[i-1];
            assign left_gt    = cell_gt[i-1];
            assign wave_in    = cell_wave[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            // shifting in from beyond the end brings an empty slot
            assign right_entry = '0;
        end
        else
        begin : g_mid
            assign right_entry = cell_entry[i+1];
        end

        imqt_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .left_entry  (left_entry),
            .left_gt     (left_gt),
            .right_entry (right_entry),
            .wave_in     (wave_in),
            .entry       (cell_entry[i]),
            .gt          (cell_gt[i]),
            .wave_out    (cell_wave[i])
        );

        assign valid_vec[i] = cell_entry[i].valid;
        assign tok_vec[i]   = cell_wave[i].tok;
    end

    // held tasks stay packed toward cell 0
    `IMQT_ASSERT_ALWAYS(a_chain_packed, clk, rst_n,
        (valid_vec & (valid_vec + QUEUE_DEPTH'(1))) == '0)

    // the first two cells are strictly ordered by key once no gap is being closed
    `IMQT_ASSERT_IMPLY(a_head_sorted, clk, rst_n, cell_entry[1].valid && tok_vec == '0,
        key_gt(cell_entry[0].prio, cell_entry[0].task_id,
               cell_entry[1].prio, cell_entry[1].task_id))

    // at most one search token walks the chain
    `IMQT_ASSERT_ALWAYS(a_single_token, clk, rst_n, $onehot0(tok_vec))

    // no search may be under way while a command is being taken
    `IMQT_ASSERT_IMPLY(a_idle_no_token, clk, rst_n, in_ready, tok_vec == '0)

endmodule

/* tb/testbench.sv */
// self-checking testbench for indexed_max_priority_task_queue_unit
// depends on imqt_pkg and the unit rtl; tracks the queue contents and checks every reply
`timescale 1ns / 100ps

module testbench;

    import imqt_pkg::*;

    localparam int DEPTH         = QUEUE_DEPTH_DEF;
    localparam int RANDOM_ITEMS  = 1580;
    localparam int LONG_HOLD     = 300;
    // worst command walks the whole chain, plus margin for the output register
    localparam int SETTLE_CYCLES = DEPTH + 20;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int REPORT_MAX    = 10;

    // shape of one random episode
    typedef enum int {
        MODE_FLOOD,
        MODE_DRAIN,
        MODE_MIXED
    } traffic_mode_t;

    // shadow copy of the held tasks and the replies they imply
    class task_queue_shadow;
        typedef struct packed {
            logic [USER_W-1:0] user;
            status_t           st;
        } reply_t;

        bit                held  [DEPTH];
        logic [ID_W-1:0]   ids   [DEPTH];
        logic [USER_W-1:0] users [DEPTH];
        logic [PRIO_W-1:0] prios [DEPTH];
        reply_t            pending_replies[$];
        int                mismatches;

        function new();
            foreach (held[i])
                held[i] = 1'b0;
            mismatches = 0;
        endfunction

        function int slot_of(logic [ID_W-1:0] id);
            foreach (held[i])
                if (held[i] && ids[i] == id)
                    return i;
            return -1;
        endfunction

        function int held_count();
            int n;
            n = 0;
            foreach (held[i])
                if (held[i])
                    n++;
            return n;
        endfunction

        function logic [ID_W-1:0] random_held_id();
            int pick;
            pick = $urandom_range(held_count() - 1);
            foreach (held[i])
                if (held[i])
                begin
                    if (pick == 0)
                        return ids[i];
                    pick--;
                end
            return '0;
        endfunction

        function int pending();
            return pending_replies.size();
        endfunction

        // apply one accepted command and queue the reply it must produce
        function void record_command(op_t o, logic [ID_W-1:0] id, logic [USER_W-1:0] owner,
                                     logic [PRIO_W-1:0] pr);
            reply_t r;
            int     s;
            r.user = '0;
            r.st   = ST_OK;
            s      = slot_of(id);
            case (o)
                OP_ADD:
                begin
                    if (s < 0)
                        foreach (held[i])
                            if (!held[i] && s < 0)
                                s = i;
                    if (s < 0)
                        r.st = ST_FULL;
                    else
                    begin
                        held[s]  = 1'b1;
                        ids[s]   = id;
                        users[s] = owner;
                        prios[s] = pr;
                    end
                end
                OP_EDIT:
                begin
                    if (s < 0)
                        r.st = ST_NOT_FOUND;
                    else
                        prios[s] = pr;
                end
                OP_REMOVE:
                begin
                    if (s < 0)
                        r.st = ST_NOT_FOUND;
                    else
                        held[s] = 1'b0;
                end
                default:
                begin
                    s = -1;
                    foreach (held[i])
                        if (held[i] && (s < 0 || {prios[i], ids[i]} > {prios[s], ids[s]}))
                            s = i;
                    if (s < 0)
                        r.st = ST_EMPTY;
                    else
                    begin
                        r.user  = users[s];
                        held[s] = 1'b0;
                    end
                end
            endcase
            pending_replies.push_back(r);
        endfunction

        function void check_result(logic [USER_W-1:0] user, logic [1:0] st);
            reply_t want;
            if (pending_replies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected reply: user %h st %0d", user, st);
                return;
            end
            want = pending_replies.pop_front();
            if (user !== want.user || st !== want.st)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("reply mismatch: expected user %h st %s, got user %h st %0d",
                             want.user, want.st.name(), user, st);
            end
        endfunction
    endclass

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid;
    logic              in_ready;
    logic [1:0]        op;
    logic [ID_W-1:0]   task_id;
    logic [USER_W-1:0] owner_id;
    logic [PRIO_W-1:0] prio;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [USER_W-1:0] user_out;
    logic [1:0]        status;

    // long receiver hold-off, armed once by the stimulus
    logic              hold_req   = 1'b0;
    logic              hold_armed = 1'b1;
    int                hold_left  = 0;

    // idle chance per cycle, in percent
    int                tx_idle_pct;
    int                rx_idle_pct;
    int                cycle_count;

    task_queue_shadow  shadow = new();

    indexed_max_priority_task_queue_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .task_id   (task_id),
        .owner_id  (owner_id),
        .prio      (prio),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .user_out  (user_out),
        .status    (status)
    );

    always #4 clk = ~clk;

    // receiver: check every reply transfer, then decide ready for the next cycle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
                shadow.check_result(user_out, status);
            out_ready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // hold-off counter, runs once when the stimulus asks for it
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left  <= 0;
            hold_armed <= 1'b1;
        end
        else if (hold_req && hold_armed)
        begin
            hold_left  <= LONG_HOLD;
            hold_armed <= 1'b0;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // offer one command and wait for its transfer; valid stays up on return
    task automatic send_cmd(input op_t o, input logic [ID_W-1:0] id,
                            input logic [USER_W-1:0] owner, input logic [PRIO_W-1:0] pr);
        in_valid <= 1'b1;
        op       <= o;
        task_id  <= id;
        owner_id <= owner;
        prio     <= pr;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        shadow.record_command(o, id, owner, pr);
    endtask

    // sender-side gaps between commands
    task automatic sender_gap();
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // stop offering until every reply is back
    task automatic pause_until_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (shadow.pending() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    function automatic logic [PRIO_W-1:0] pick_prio();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            return $urandom();
        else if (r < 60)
            return r[0] ? '1 : '0;
        return $urandom_range(7);   // narrow range so ties on priority are common
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return ID_W'($urandom_range(255));
        else if (r < 90)
            return ID_W'($urandom_range(4095));
        return ID_W'($urandom());
    endfunction

    // one random command; edit and remove mostly aim at a held task
    task automatic random_cmd(input traffic_mode_t mode);
        int              r;
        op_t             o;
        logic [ID_W-1:0] id;
        r  = $urandom_range(99);
        id = pick_id();
        case (mode)
            MODE_FLOOD: o = (r < 85) ? OP_ADD : (r < 90) ? OP_EDIT :
                            (r < 95) ? OP_TAKE : OP_REMOVE;
            MODE_DRAIN: o = (r < 55) ? OP_TAKE : (r < 75) ? OP_REMOVE :
                            (r < 85) ? OP_EDIT : OP_ADD;
            default:    o = op_t'(r[1:0]);
        endcase
        // hit a held id for edit/remove, and sometimes re-add one to replace it
        if (shadow.held_count() > 0 && $urandom_range(99) < 75 &&
            (o == OP_EDIT || o == OP_REMOVE || (o == OP_ADD && r % 5 == 0)))
            id = shadow.random_held_id();
        sender_gap();
        send_cmd(o, id, USER_W'($urandom()), pick_prio());
    endtask

    // extremes of every field, each op, ties, replace, absent ids and empty take
    task automatic run_directed();
        send_cmd(OP_TAKE,   16'h0000, 16'h1234, 32'h0000_0001);   // take on empty
        send_cmd(OP_EDIT,   16'h0005, 16'hffff, 32'hffff_ffff);   // edit absent id
        send_cmd(OP_REMOVE, 16'h0005, 16'hffff, 32'hffff_ffff);   // remove absent id
        send_cmd(OP_ADD,    16'h0000, 16'hffff, 32'h0000_0000);
        send_cmd(OP_ADD,    16'hffff, 16'h0000, 32'hffff_ffff);
        send_cmd(OP_ADD,    16'h1234, 16'haaaa, 32'hffff_ffff);   // tie, larger id wins
        send_cmd(OP_ADD,    16'h1234, 16'h5555, 32'h0000_0007);   // add of held id replaces
        send_cmd(OP_EDIT,   16'h0000, 16'h9999, 32'hffff_ffff);
        send_cmd(OP_TAKE,   16'hffff, 16'hffff, 32'hffff_ffff);   // unused fields at max
        send_cmd(OP_TAKE,   16'h0000, 16'h0000, 32'h0000_0000);
        send_cmd(OP_TAKE,   16'h0000, 16'h0000, 32'h0000_0000);
        send_cmd(OP_TAKE,   16'h0000, 16'h0000, 32'h0000_0000);   // empty again
        send_cmd(OP_ADD,    16'h0007, 16'h0001, 32'h0000_0064);
        send_cmd(OP_ADD,    16'h0008, 16'h0002, 32'h0000_0064);
        send_cmd(OP_ADD,    16'h0009, 16'h0003, 32'h0000_0032);
        send_cmd(OP_REMOVE, 16'h0008, 16'hffff, 32'hffff_ffff);
        send_cmd(OP_REMOVE, 16'h0008, 16'h0000, 32'h0000_0000);   // already gone
        send_cmd(OP_EDIT,   16'h0009, 16'hffff, 32'h0000_00c8);
        send_cmd(OP_TAKE,   16'h0007, 16'h0000, 32'h0000_0000);
        send_cmd(OP_TAKE,   16'h0000, 16'h0000, 32'h0000_0000);
        send_cmd(OP_TAKE,   16'h0000, 16'h0000, 32'h0000_0000);
    endtask

    // watchdog on total run length
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int            sent;
        int            span;
        int            r;
        traffic_mode_t mode;
        in_valid    <= 1'b0;
        op          <= OP_ADD;
        task_id     <= '0;
        owner_id    <= '0;
        prio        <= '0;
        tx_idle_pct = 14;
        rx_idle_pct = 73;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        pause_until_drained();

        // three idling profiles: slow receiver, slow sender, then no idling at all
        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 73 : 0;
            rx_idle_pct = (phase == 0) ? 73 : (phase == 1) ? 14 : 0;
            // receiver blocks for a long stretch while commands keep coming
            if (phase == 2)
                hold_req <= 1'b1;
            sent = 0;
            while (sent < RANDOM_ITEMS / 3)
            begin
                r    = $urandom_range(99);
                mode = (r < 35) ? MODE_FLOOD : (r < 65) ? MODE_DRAIN : MODE_MIXED;
                span = $urandom_range(100, 20);
                repeat (span)
                    random_cmd(mode);
                sent += span;
            end
            pause_until_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (shadow.pending() != 0)
            $display("%0d expected replies never arrived", shadow.pending());

        if (shadow.mismatches == 0 && shadow.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
